/* src/ifhp_pkg.sv */
package ifhp_pkg;

    localparam logic [15:0] ETH_IPV4    = 16'd2048;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IHL_MASK    = 4'hF;
    localparam logic [3:0]  IHL_MIN     = 4'h4 + 4'h1;
    localparam logic [7:0]  ETH_HDR     = 8'd14;
    localparam logic [7:0]  UDP_HDR     = 8'd8;
    localparam logic [7:0]  TCP_MIN_HDR = 8'd20;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam logic [15:0] POS_MIN_LAST = 16'd23;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_BAD,
        KIND_FLOW
    } kind_t;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_word;
        logic [31:0] ack_word;
        logic [15:0] tlo;
    } capture_t;

    typedef struct packed {
        kind_t       kind;
        logic        tcp;
        logic [3:0]  ihl;
        logic [15:0] total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_word;
        logic [31:0] ack_word;
        logic [15:0] tlo;
    } record_t;

endpackage

/* src/ipv4_flow_header_parser.sv */
// IPv4 TCP/UDP five-tuple parser.
// Input channel: one frame byte per request (data_byte, last_byte), starting
// at the Ethernet destination address; in_valid/in_stall handshake.
// Output channel: one result request per frame, produced after the byte that
// carries last_byte; out_valid/out_stall handshake.
// Throughput: one byte per cycle while in_stall is low; producing a result does not hold the input.
// After the last byte is accepted the header is written to the queue, then loaded
// into the output register (raising out_valid) once that register is free.
// A two-entry queue holds finished headers between the byte parser and the
// result stage; in_stall rises only when both entries are taken, i.e. when
// out_stall has held the output register and the queue fills behind it.
// Addresses come out in canonical order, lower address first with its port.
// Reset clears the byte counter, captured fields, queue and output valid.
module ipv4_flow_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_flow,
    output logic        is_tcp,
    output logic [31:0] ip_low,
    output logic [15:0] port_low,
    output logic [31:0] ip_high,
    output logic [15:0] port_high,
    output logic        direction,
    output logic [31:0] seq_num,
    output logic [31:0] ack_num,
    output logic [7:0]  payload_offset,
    output logic [15:0] payload_length,
    output logic        length_bad
);
    import ifhp_pkg::*;

    record_t push_rec;
    record_t head_rec;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;

    ifhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    ifhp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_rec (head_rec)
    );

    ifhp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head_rec       (head_rec),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_flow        (is_flow),
        .is_tcp         (is_tcp),
        .ip_low         (ip_low),
        .port_low       (port_low),
        .ip_high        (ip_high),
        .port_high      (port_high),
        .direction      (direction),
        .seq_num        (seq_num),
        .ack_num        (ack_num),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .length_bad     (length_bad)
    );

endmodule

/* src/ifhp_front.sv */
module ifhp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             q_full,
    output logic             push,
    output ifhp_pkg::record_t rec
);
    import ifhp_pkg::*;

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    capture_t    cap_reg;
    capture_t    cap_next;
    capture_t    cap;
    logic        accept;
    logic [7:0]  hdr_end;
    logic [15:0] rel;
    logic [16:0] frame_len;
    logic [7:0]  need;
    logic        is_tcp;
    logic        is_udp;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && last_byte;

    always_comb
    begin
        cap     = cap_reg;
        hdr_end = ETH_HDR + {2'b00, cap_reg.ihl, 2'b00};
        rel     = '0;
        if (pos_reg == 16'd12 || pos_reg == 16'd13)
        begin
            cap.ether_type = {cap_reg.ether_type[7:0], data_byte};
        end
        else if (pos_reg == 16'd14)
        begin
            cap.ihl = data_byte[3:0] & IHL_MASK;
        end
        else if (pos_reg == 16'd16 || pos_reg == 16'd17)
        begin
            cap.total_length = {cap_reg.total_length[7:0], data_byte};
        end
        else if (pos_reg == 16'd23)
        begin
            cap.protocol = data_byte;
        end
        else if (pos_reg >= 16'd26 && pos_reg <= 16'd29)
        begin
            cap.src_addr = {cap_reg.src_addr[23:0], data_byte};
        end
        else if (pos_reg >= 16'd30 && pos_reg <= 16'd33)
        begin
            cap.dst_addr = {cap_reg.dst_addr[23:0], data_byte};
        end

        // transport header sits right after the IP options
        hdr_end = ETH_HDR + {2'b00, cap.ihl, 2'b00};
        if (cap.ihl >= IHL_MIN && pos_reg >= {8'd0, hdr_end})
        begin
            rel = pos_reg - {8'd0, hdr_end};
            if (rel < 16'd2)
            begin
                cap.src_port = {cap_reg.src_port[7:0], data_byte};
            end
            else if (rel < 16'd4)
            begin
                cap.dst_port = {cap_reg.dst_port[7:0], data_byte};
            end
            else if (cap.protocol == PROTO_TCP)
            begin
                if (rel < 16'd8)
                begin
                    cap.seq_word = {cap_reg.seq_word[23:0], data_byte};
                end
                else if (rel < 16'd12)
                begin
                    cap.ack_word = {cap_reg.ack_word[23:0], data_byte};
                end
                else if (rel == 16'd12)
                begin
                    cap.tlo = {8'd0, data_byte};
                end
            end
            else if (cap.protocol == PROTO_UDP)
            begin
                if (rel < 16'd6)
                begin
                    cap.tlo = {cap_reg.tlo[7:0], data_byte};
                end
            end
        end
    end

    // classify the finished frame
    always_comb
    begin
        is_tcp    = (cap.protocol == PROTO_TCP);
        is_udp    = (cap.protocol == PROTO_UDP);
        frame_len = {1'b0, pos_reg} + 17'd1;
        need      = ETH_HDR + {2'b00, cap.ihl, 2'b00} + (is_tcp ? TCP_MIN_HDR : UDP_HDR);
        rec.tcp          = is_tcp;
        rec.ihl          = cap.ihl;
        rec.total_length = cap.total_length;
        rec.src_addr     = cap.src_addr;
        rec.dst_addr     = cap.dst_addr;
        rec.src_port     = cap.src_port;
        rec.dst_port     = cap.dst_port;
        rec.seq_word     = cap.seq_word;
        rec.ack_word     = cap.ack_word;
        rec.tlo          = cap.tlo;
        if (pos_reg < POS_MIN_LAST)
        begin
            rec.kind = KIND_BAD;
        end
        else if (cap.ether_type != ETH_IPV4 || !(is_tcp || is_udp))
        begin
            rec.kind = KIND_OTHER;
        end
        else if (cap.ihl < IHL_MIN || frame_len < {9'd0, need})
        begin
            rec.kind = KIND_BAD;
        end
        else
        begin
            rec.kind = KIND_FLOW;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        cap_next = cap_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                cap_next = '0;
            end
            else
            begin
                cap_next = cap;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cap_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            cap_reg <= cap_next;
        end
    end

endmodule

/* src/ifhp_queue.sv */
module ifhp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ifhp_pkg::record_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output ifhp_pkg::record_t head_rec
);
    import ifhp_pkg::*;

    record_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !q_valid)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

/* src/ifhp_back.sv */
module ifhp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ifhp_pkg::record_t head_rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              is_flow,
    output logic              is_tcp,
    output logic [31:0]       ip_low,
    output logic [15:0]       port_low,
    output logic [31:0]       ip_high,
    output logic [15:0]       port_high,
    output logic              direction,
    output logic [31:0]       seq_num,
    output logic [31:0]       ack_num,
    output logic [7:0]        payload_offset,
    output logic [15:0]       payload_length,
    output logic              length_bad
);
    import ifhp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        flow;
    logic        swap;
    logic [7:0]  ip_len;
    logic [7:0]  tcp_len;
    logic [7:0]  hdr_sum;
    logic        neg;
    logic [15:0] plen;

    logic        is_flow_reg;
    logic        is_tcp_reg;
    logic [31:0] ip_low_reg;
    logic [15:0] port_low_reg;
    logic [31:0] ip_high_reg;
    logic [15:0] port_high_reg;
    logic        direction_reg;
    logic [31:0] seq_num_reg;
    logic [31:0] ack_num_reg;
    logic [7:0]  offset_reg;
    logic [15:0] plen_reg;
    logic        bad_reg;

    assign pop        = q_valid && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_comb
    begin
        flow    = (head_rec.kind == KIND_FLOW);
        swap    = head_rec.src_addr > head_rec.dst_addr;
        ip_len  = {2'b00, head_rec.ihl, 2'b00};
        tcp_len = {2'b00, head_rec.tlo[7:4], 2'b00};
        if (head_rec.tcp)
        begin
            hdr_sum = ip_len + tcp_len;
            neg     = head_rec.total_length < {8'd0, hdr_sum};
            plen    = head_rec.total_length - {8'd0, hdr_sum};
        end
        else
        begin
            hdr_sum = ip_len + UDP_HDR;
            neg     = head_rec.tlo < {8'd0, UDP_HDR};
            plen    = head_rec.tlo - {8'd0, UDP_HDR};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_flow_reg   <= flow;
            is_tcp_reg    <= flow && head_rec.tcp;
            ip_low_reg    <= !flow ? '0 : (swap ? head_rec.dst_addr : head_rec.src_addr);
            port_low_reg  <= !flow ? '0 : (swap ? head_rec.dst_port : head_rec.src_port);
            ip_high_reg   <= !flow ? '0 : (swap ? head_rec.src_addr : head_rec.dst_addr);
            port_high_reg <= !flow ? '0 : (swap ? head_rec.src_port : head_rec.dst_port);
            direction_reg <= flow && swap;
            seq_num_reg   <= (flow && head_rec.tcp) ? head_rec.seq_word : '0;
            ack_num_reg   <= (flow && head_rec.tcp) ? head_rec.ack_word : '0;
            offset_reg    <= flow ? (ETH_HDR + hdr_sum) : '0;
            plen_reg      <= (flow && !neg) ? plen : '0;
            bad_reg       <= (head_rec.kind == KIND_BAD) || (flow && neg);
        end
    end

    assign out_valid      = valid_reg;
    assign is_flow        = is_flow_reg;
    assign is_tcp         = is_tcp_reg;
    assign ip_low         = ip_low_reg;
    assign port_low       = port_low_reg;
    assign ip_high        = ip_high_reg;
    assign port_high      = port_high_reg;
    assign direction      = direction_reg;
    assign seq_num        = seq_num_reg;
    assign ack_num        = ack_num_reg;
    assign payload_offset = offset_reg;
    assign payload_length = plen_reg;
    assign length_bad     = bad_reg;

endmodule

/* sim/ipv4_flow_header_parser_tb.sv */
module ipv4_flow_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        is_flow;
        logic        is_tcp;
        logic [31:0] ip_low;
        logic [15:0] port_low;
        logic [31:0] ip_high;
        logic [15:0] port_high;
        logic        direction;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
        logic        length_bad;
    } tuple_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        is_flow;
    logic        is_tcp;
    logic [31:0] ip_low;
    logic [15:0] port_low;
    logic [31:0] ip_high;
    logic [15:0] port_high;
    logic        direction;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
    logic        length_bad;

    ipv4_flow_header_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .is_flow(is_flow), .is_tcp(is_tcp),
        .ip_low(ip_low), .port_low(port_low),
        .ip_high(ip_high), .port_high(port_high),
        .direction(direction), .seq_num(seq_num), .ack_num(ack_num),
        .payload_offset(payload_offset), .payload_length(payload_length),
        .length_bad(length_bad)
    );

    // parser state mirror
    logic [15:0] pos_q;
    logic [15:0] etype_q;
    logic [3:0]  ihl_q;
    logic [15:0] tot_len_q;
    logic [7:0]  proto_q;
    logic [31:0] src_ip_q;
    logic [31:0] dst_ip_q;
    logic [15:0] src_port_q;
    logic [15:0] dst_port_q;
    logic [31:0] seq_q;
    logic [31:0] ack_q;
    logic [15:0] tlo_q;

    tuple_t expected_tuples[$];
    int     mismatches;
    int     idle_pct;
    int     stall_pct;
    bit     hold_off;
    int     quiet_cycles;
    bit     timed_out;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parser();
        pos_q = '0; etype_q = '0; ihl_q = '0; tot_len_q = '0; proto_q = '0;
        src_ip_q = '0; dst_ip_q = '0; src_port_q = '0; dst_port_q = '0;
        seq_q = '0; ack_q = '0; tlo_q = '0;
    endfunction

    function automatic tuple_t close_frame(int unsigned flen);
        tuple_t t;
        bit tcp;
        int unsigned ip_len;
        int unsigned tcp_len;
        int unsigned need;
        int plen;
        bit swap;
        t = '0;
        tcp = (proto_q == PROTO_TCP);
        ip_len = ihl_q * 4;
        if (flen < 24)
        begin
            t.length_bad = 1'b1;
            return t;
        end
        if (etype_q != ETH_IPV4 || (!tcp && proto_q != PROTO_UDP))
            return t;
        if (ihl_q < IHL_MIN)
        begin
            t.length_bad = 1'b1;
            return t;
        end
        need = ETH_HDR + ip_len + (tcp ? TCP_MIN_HDR : UDP_HDR);
        if (flen < need)
        begin
            t.length_bad = 1'b1;
            return t;
        end
        if (tcp)
        begin
            tcp_len = tlo_q[7:4] * 4;
            t.payload_offset = 8'(ETH_HDR + ip_len + tcp_len);
            plen = int'(tot_len_q) - int'(ip_len) - int'(tcp_len);
        end
        else
        begin
            t.payload_offset = 8'(ETH_HDR + ip_len + UDP_HDR);
            plen = int'(tlo_q) - int'(UDP_HDR);
        end
        if (plen < 0)
        begin
            plen = 0;
            t.length_bad = 1'b1;
        end
        swap = src_ip_q > dst_ip_q;
        t.is_flow = 1'b1;
        t.is_tcp = tcp;
        t.ip_low = swap ? dst_ip_q : src_ip_q;
        t.port_low = swap ? dst_port_q : src_port_q;
        t.ip_high = swap ? src_ip_q : dst_ip_q;
        t.port_high = swap ? src_port_q : dst_port_q;
        t.direction = swap;
        t.seq_num = tcp ? seq_q : '0;
        t.ack_num = tcp ? ack_q : '0;
        t.payload_length = 16'(plen);
        return t;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        int unsigned p;
        int unsigned h;
        int unsigned r;
        p = pos_q;
        if (p == 12 || p == 13) etype_q = {etype_q[7:0], b};
        else if (p == 14) ihl_q = b[3:0] & IHL_MASK;
        else if (p == 16 || p == 17) tot_len_q = {tot_len_q[7:0], b};
        else if (p == 23) proto_q = b;
        else if (p >= 26 && p <= 29) src_ip_q = {src_ip_q[23:0], b};
        else if (p >= 30 && p <= 33) dst_ip_q = {dst_ip_q[23:0], b};
        if (ihl_q >= IHL_MIN)
        begin
            h = ETH_HDR + ihl_q * 4;
            if (p >= h)
            begin
                r = p - h;
                if (r < 2) src_port_q = {src_port_q[7:0], b};
                else if (r < 4) dst_port_q = {dst_port_q[7:0], b};
                else if (proto_q == PROTO_TCP)
                begin
                    if (r < 8) seq_q = {seq_q[23:0], b};
                    else if (r < 12) ack_q = {ack_q[23:0], b};
                    else if (r == 12) tlo_q = {8'h00, b};
                end
                else if (proto_q == PROTO_UDP)
                begin
                    if (r < 6) tlo_q = {tlo_q[7:0], b};
                end
            end
        end
        if (last)
        begin
            expected_tuples = {expected_tuples, close_frame(p + 1)};
            clear_parser();
        end
        else if (pos_q != POS_MAX)
        begin
            pos_q = pos_q + 16'd1;
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parse_byte(b, last);
    endtask

    // frame of given length; fields taken from args, rest random
    task automatic send_frame(int len, logic [15:0] etype, logic [7:0] ihl_b,
                              logic [15:0] tot, logic [7:0] proto, logic [7:0] doff,
                              logic [15:0] ulen, bit fixed_ip, logic [31:0] sip,
                              logic [31:0] dip);
        logic [7:0] b;
        int h;
        for (int i = 0; i < len; i++)
        begin
            h = 14 + ihl_b[3:0] * 4;
            b = 8'($urandom);
            if (i == 12) b = etype[15:8];
            else if (i == 13) b = etype[7:0];
            else if (i == 14) b = ihl_b;
            else if (i == 16) b = tot[15:8];
            else if (i == 17) b = tot[7:0];
            else if (i == 23) b = proto;
            else if (fixed_ip && i >= 26 && i <= 29) b = sip[8*(29-i) +: 8];
            else if (fixed_ip && i >= 30 && i <= 33) b = dip[8*(33-i) +: 8];
            else if (i == h + 12 && proto == PROTO_TCP) b = doff;
            else if (i == h + 4 && proto == PROTO_UDP) b = ulen[15:8];
            else if (i == h + 5 && proto == PROTO_UDP) b = ulen[7:0];
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic random_frame();
        int k;
        int ihl;
        int len;
        logic [7:0] proto;
        k = $urandom_range(99, 0);
        ihl = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 5) : 5;
        proto = $urandom_range(1, 0) ? PROTO_TCP : PROTO_UDP;
        len = 14 + ihl * 4 + (proto == PROTO_TCP ? 20 : 8) + $urandom_range(12, 0);
        if (k < 75)
            send_frame(len, ETH_IPV4, {4'h4, 4'(ihl)}, 16'($urandom), proto,
                       8'($urandom), ($urandom_range(1, 0) ? 16'($urandom_range(80, 0))
                       : 16'($urandom)), $urandom_range(3, 0) == 0, 32'h0a000001,
                       ($urandom_range(1, 0) ? 32'h0a000001 : 32'($urandom)));
        else if (k < 85)
            send_frame($urandom_range(40, 1), ETH_IPV4, 8'($urandom), 16'($urandom),
                       proto, 8'($urandom), 16'($urandom), 1'b0, '0, '0);
        else
            send_frame($urandom_range(60, 1), 16'($urandom), 8'($urandom),
                       16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                       1'b0, '0, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_tuples.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0; stall_pct = 0;
        send_byte(8'hFF, 1'b1);
        send_frame(23, ETH_IPV4, 8'h45, 16'd60, PROTO_TCP, 8'h50, 0, 1'b0, '0, '0);
        send_frame(24, 16'h86DD, 8'h45, 16'd60, PROTO_TCP, 8'h50, 0, 1'b0, '0, '0);
        send_frame(24, ETH_IPV4, 8'h45, 16'd60, 8'd1, 8'h50, 0, 1'b0, '0, '0);
        send_frame(24, ETH_IPV4, 8'h44, 16'd60, PROTO_TCP, 8'h50, 0, 1'b0, '0, '0);
        send_frame(41, ETH_IPV4, 8'h45, 16'd60, PROTO_UDP, 8'h50, 16'd20, 1'b0, '0, '0);
        // swapped addresses with a negative payload length
        send_frame(54, ETH_IPV4, 8'h45, 16'd10, PROTO_TCP, 8'h30, 0, 1'b1,
                   32'hFFFFFFFF, 32'h00000000);
        send_frame(42, ETH_IPV4, 8'h45, 16'd0, PROTO_UDP, 8'h00, 16'd0, 1'b1,
                   32'h01020304, 32'h01020304);
        // largest payload offset
        send_frame(94, ETH_IPV4, 8'hFF, 16'd200, PROTO_TCP, 8'hF0, 0, 1'b0, '0, '0);
        wait_drained();
    endtask

    task automatic test_random(int frames, int ip, int sp);
        idle_pct = ip; stall_pct = sp;
        for (int i = 0; i < frames; i++) random_frame();
        idle_pct = 0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0; stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_frame(3, ETH_IPV4, 8'h45, 16'd60, PROTO_UDP, 0, 16'd30,
                           1'b0, '0, '0);
        join
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        tuple_t got;
        tuple_t exp_t;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{is_flow, is_tcp, ip_low, port_low, ip_high, port_high, direction,
                    seq_num, ack_num, payload_offset, payload_length, length_bad};
            if (expected_tuples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                exp_t = expected_tuples.pop_front();
                if (got !== exp_t)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_t, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        clear_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(2, 0, 0);
        test_random(2, 84, 0);
        test_random(2, 0, 84);
        test_random(2, 34, 34);
        test_backpressure();
        if (mismatches == 0 && expected_tuples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* ipv4_flow_header_parser.f */
src/ifhp_pkg.sv
src/ifhp_front.sv
src/ifhp_queue.sv
src/ifhp_back.sv
src/ipv4_flow_header_parser.sv
sim/ipv4_flow_header_parser_tb.sv
